@@ src/code_length_run_length_encoder_assert.svh @@
// Assertion macros shared by the encoder's checker.
`ifndef CODE_LENGTH_RUN_LENGTH_ENCODER_ASSERT_SVH
`define CODE_LENGTH_RUN_LENGTH_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define CLRLE_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("clrle: same-cycle check failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define CLRLE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("clrle: next-cycle check failed");

`endif

@@ src/clrle_pkg.sv @@
// Types, symbol codes and the run flush function of the code length encoder.
package clrle_pkg;

    // Code length alphabet symbols
    localparam logic [4:0] SYM_REPEAT     = 5'd16;
    localparam logic [4:0] SYM_ZERO_SHORT = 5'd17;
    localparam logic [4:0] SYM_ZERO_LONG  = 5'd18;

    // Extra bit widths per symbol
    localparam logic [2:0] BITS_REPEAT     = 3'd2;
    localparam logic [2:0] BITS_ZERO_SHORT = 3'd3;
    localparam logic [2:0] BITS_ZERO_LONG  = 3'd7;

    // Run limits
    localparam logic [7:0] RUN_MIN        = 8'd3;
    localparam logic [7:0] REPEAT_MAX     = 8'd6;
    localparam logic [7:0] ZERO_SHORT_MAX = 8'd10;
    localparam logic [7:0] ZERO_LONG_MIN  = 8'd11;
    localparam logic [7:0] ZERO_LONG_MAX  = 8'd138;

    // Results per input item, and candidate results before packing
    localparam int MAX_RES  = 3;
    localparam int NUM_CAND = 5;

    typedef struct packed {
        logic [4:0] symbol;
        logic [6:0] extra;
        logic [2:0] bits;
    } res_t;

    // Up to two results that a pending run stands for
    typedef struct packed {
        logic [1:0]       n;
        res_t [1:0]       res;
    } flush_t;

    // All results of one input item, res[0] goes out first
    typedef struct packed {
        logic             last;
        logic [1:0]       cnt;
        res_t [MAX_RES-1:0] res;
    } bundle_t;

    // Queue write port
    typedef struct packed {
        logic    valid;
        bundle_t data;
    } qwrite_t;

    function automatic res_t make_res(logic [4:0] sym, logic [6:0] extra, logic [2:0] bits);
        res_t r;
        r.symbol = sym;
        r.extra  = extra;
        r.bits   = bits;
        return r;
    endfunction

    // What a pending run of cnt copies of prev turns into
    function automatic flush_t flush_run(logic [3:0] prev, logic [7:0] cnt);
        flush_t     f;
        logic [7:0] short_extra;
        logic [7:0] long_extra;
        short_extra = cnt - RUN_MIN;
        long_extra  = cnt - ZERO_LONG_MIN;
        f = '0;
        if (cnt >= RUN_MIN) begin
            f.n = 2'd1;
            if (prev != 4'd0) begin
                f.res[0] = make_res(SYM_REPEAT, short_extra[6:0], BITS_REPEAT);
            end else if (cnt <= ZERO_SHORT_MAX) begin
                f.res[0] = make_res(SYM_ZERO_SHORT, short_extra[6:0], BITS_ZERO_SHORT);
            end else begin
                f.res[0] = make_res(SYM_ZERO_LONG, long_extra[6:0], BITS_ZERO_LONG);
            end
        end else begin
            // one or two copies go out as literals
            f.n      = cnt[1:0];
            f.res[0] = make_res({1'b0, prev}, 7'd0, 3'd0);
            f.res[1] = make_res({1'b0, prev}, 7'd0, 3'd0);
        end
        return f;
    endfunction

endpackage

@@ src/clrle_front.sv @@
// Front end: run tracking and classification of each code length into result bundles.
module clrle_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [3:0]           code_length,
    input  logic                 last_length,
    output clrle_pkg::qwrite_t   qwr
);

    logic [3:0] prev_reg, prev_next;
    logic [7:0] count_reg, count_next;

    logic              eq;
    logic [7:0]        cnt_inc;
    logic [3:0]        prev1;
    logic [7:0]        cnt1;
    logic              mid_v;
    clrle_pkg::res_t   mid_res;
    clrle_pkg::flush_t fa;
    clrle_pkg::flush_t fb;
    clrle_pkg::res_t   cand   [clrle_pkg::NUM_CAND];
    logic              cand_v [clrle_pkg::NUM_CAND];
    clrle_pkg::res_t [clrle_pkg::MAX_RES-1:0] slot;
    logic [2:0]        k;

    // Run bookkeeping for this item
    always_comb begin
        eq      = (code_length == prev_reg);
        cnt_inc = count_reg + 8'd1;
        fa      = clrle_pkg::flush_run(prev_reg, count_reg);
        mid_v   = 1'b0;
        mid_res = clrle_pkg::make_res({1'b0, code_length}, 7'd0, 3'd0);
        prev1   = code_length;
        cnt1    = cnt_inc;
        if (eq) begin
            if (prev_reg != 4'd0 && cnt_inc >= clrle_pkg::REPEAT_MAX) begin
                mid_v   = 1'b1;
                mid_res = clrle_pkg::make_res(clrle_pkg::SYM_REPEAT, 7'd3,
                                              clrle_pkg::BITS_REPEAT);
                cnt1    = 8'd0;
            end else if (prev_reg == 4'd0 && cnt_inc >= clrle_pkg::ZERO_LONG_MAX) begin
                mid_v   = 1'b1;
                mid_res = clrle_pkg::make_res(clrle_pkg::SYM_ZERO_LONG, 7'd127,
                                              clrle_pkg::BITS_ZERO_LONG);
                cnt1    = 8'd0;
            end
        end else begin
            // new length: literal if nonzero, else a zero run starts
            mid_v = (code_length != 4'd0);
            cnt1  = (code_length != 4'd0) ? 8'd0 : 8'd1;
        end
        fb = clrle_pkg::flush_run(prev1, cnt1);
    end

    // Candidate results in output order
    always_comb begin
        cand[0]   = fa.res[0];
        cand_v[0] = !eq && (fa.n != 2'd0);
        cand[1]   = fa.res[1];
        cand_v[1] = !eq && (fa.n == 2'd2);
        cand[2]   = mid_res;
        cand_v[2] = mid_v;
        cand[3]   = fb.res[0];
        cand_v[3] = last_length && (fb.n != 2'd0);
        cand[4]   = fb.res[1];
        cand_v[4] = last_length && (fb.n == 2'd2);
    end

    // Pack valid candidates into the bundle slots
    always_comb begin
        slot = '0;
        k    = 3'd0;
        for (int i = 0; i < clrle_pkg::NUM_CAND; i++) begin
            if (cand_v[i]) begin
                if (k < 3'(clrle_pkg::MAX_RES)) begin
                    slot[k[1:0]] = cand[i];
                end
                k = k + 3'd1;
            end
        end
        qwr.valid     = accept && (k != 3'd0);
        qwr.data.last = last_length;
        qwr.data.cnt  = k[1:0];
        qwr.data.res  = slot;
    end

    // State update; the last item returns to the start state
    always_comb begin
        prev_next  = prev_reg;
        count_next = count_reg;
        if (accept) begin
            prev_next  = last_length ? 4'd0 : prev1;
            count_next = last_length ? 8'd0 : cnt1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= 4'd0;
            count_reg <= 8'd0;
        end else begin
            prev_reg  <= prev_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ src/clrle_queue.sv @@
// Short bundle queue between the front and back ends.
module clrle_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  clrle_pkg::qwrite_t   qwr,
    input  logic                 pop,
    output logic                 full,
    output logic                 head_valid,
    output clrle_pkg::bundle_t   head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clrle_pkg::bundle_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = qwr.valid && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= qwr.data;
        end
    end

endmodule

@@ src/clrle_back.sv @@
// Back end: serializes bundles into single results through the output register.
module clrle_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  clrle_pkg::bundle_t   head,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [4:0]           m_symbol,
    output logic [6:0]           m_repeat_extra,
    output logic [2:0]           m_extra_bit_count,
    output logic                 m_final_symbol
);

    logic            valid_reg, valid_next;
    clrle_pkg::res_t res_reg, res_next;
    logic            final_reg, final_next;
    logic [1:0]      sub_reg, sub_next;
    logic            load;
    logic            at_end;

    // Load when the output slot is free or being taken
    assign load   = head_valid && (!valid_reg || m_ready);
    assign at_end = (sub_reg == head.cnt - 2'd1);
    assign pop    = load && at_end;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        final_next = final_reg;
        sub_next   = sub_reg;
        if (load) begin
            valid_next = 1'b1;
            res_next   = head.res[sub_reg];
            final_next = head.last && at_end;
            sub_next   = at_end ? 2'd0 : sub_reg + 2'd1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sub_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        res_reg   <= res_next;
        final_reg <= final_next;
    end

    assign m_valid           = valid_reg;
    assign m_symbol          = res_reg.symbol;
    assign m_repeat_extra    = res_reg.extra;
    assign m_extra_bit_count = res_reg.bits;
    assign m_final_symbol    = final_reg;

endmodule

@@ src/code_length_run_length_encoder.sv @@
// Top level of the Deflate code length run-length encoder.
// Input channel (s_): one Huffman code length per transfer, 0 to 15, with
// s_last_length marking the final length of a sequence.
// Output channel (m_): Deflate code length symbols 0-18 with their repeat
// extra value and its bit count; m_final_symbol marks the sequence's last one.
// Each input transfer yields zero to three results; they are packed by the
// front end into one bundle, queued, and sent out one per cycle while m_ready is high.
// Throughput: one input transfer per cycle while the queue has room, and one
// result per cycle at the output while m_ready is high; an item's results go out in turn.
// With the queue empty, a result passes through the queue and then the output
// register before it becomes valid on m_.
// When the receiver stalls, the output register holds and the queue fills;
// s_ready drops only once QUEUE_DEPTH bundles are waiting.
// Reset (aresetn low, synchronous) empties the queue and output register and
// starts a new sequence; the end of a sequence does the same for run state.
module code_length_run_length_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_code_length,
    input  logic       s_last_length,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_symbol,
    output logic [6:0] m_repeat_extra,
    output logic [2:0] m_extra_bit_count,
    output logic       m_final_symbol
);

    clrle_pkg::qwrite_t qwr;
    clrle_pkg::bundle_t head;
    logic               full;
    logic               head_valid;
    logic               pop;
    logic               accept;

    assign s_ready = !full;
    assign accept  = s_valid && !full;

    clrle_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .code_length (s_code_length),
        .last_length (s_last_length),
        .qwr         (qwr)
    );

    clrle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .qwr        (qwr),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    clrle_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head_valid        (head_valid),
        .head              (head),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_symbol          (m_symbol),
        .m_repeat_extra    (m_repeat_extra),
        .m_extra_bit_count (m_extra_bit_count),
        .m_final_symbol    (m_final_symbol)
    );

endmodule

@@ src/clrle_checker.sv @@
// Port-level checks of the encoder, bound to its top level.
`include "code_length_run_length_encoder_assert.svh"

module clrle_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [3:0] s_code_length,
    input logic       s_last_length,
    input logic       m_valid,
    input logic       m_ready,
    input logic [4:0] m_symbol,
    input logic [6:0] m_repeat_extra,
    input logic [2:0] m_extra_bit_count,
    input logic       m_final_symbol
);

    logic [15:0] m_payload;
    assign m_payload = {m_symbol, m_repeat_extra, m_extra_bit_count, m_final_symbol};

    // A stalled result holds
    `CLRLE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_payload))

    // Literals carry no extra bits
    `CLRLE_ASSERT_NOW(a_literal_plain, m_valid && m_symbol < clrle_pkg::SYM_REPEAT,
        m_repeat_extra == 7'd0 && m_extra_bit_count == 3'd0)

    // Repeat symbols use their fixed extra widths, and symbols 16 and 17 their extra ranges
    `CLRLE_ASSERT_NOW(a_repeat_form, m_valid && m_symbol == clrle_pkg::SYM_REPEAT,
        m_extra_bit_count == clrle_pkg::BITS_REPEAT && m_repeat_extra <= 7'd3)
    `CLRLE_ASSERT_NOW(a_zero_form, m_valid && m_symbol >= clrle_pkg::SYM_ZERO_SHORT,
        (m_symbol == clrle_pkg::SYM_ZERO_SHORT && m_extra_bit_count == clrle_pkg::BITS_ZERO_SHORT && m_repeat_extra <= 7'd7) || (m_symbol == clrle_pkg::SYM_ZERO_LONG && m_extra_bit_count == clrle_pkg::BITS_ZERO_LONG))

endmodule

bind code_length_run_length_encoder clrle_checker u_clrle_checker (.*);

@@ sim/tb.sv @@
// Self-checking testbench for the Deflate code length run-length encoder.
`timescale 1ns / 1ps

module tb;

    localparam int NUM_DIRECTED = 25;
    localparam int RANDOM_ITEMS = 15;
    localparam int HOLD_AT      = 4;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int TIMEOUT_NS   = 2_000_000;

    // One expected symbol as it leaves the m_ channel
    typedef struct packed {
        logic [4:0] symbol;
        logic [6:0] extra;
        logic [2:0] bits;
        logic       fin;
    } sym_rec_t;

    // One code length to send, optionally with its results typed in
    typedef struct packed {
        logic [3:0]     len;
        logic           last;
        logic           typed;
        logic [1:0]     n;
        sym_rec_t [2:0] exp;
    } stim_row_t;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SLOW} sink_mode_t;

    localparam sym_rec_t NO_SYM = '0;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [3:0] s_code_length;
    logic       s_last_length;
    logic       m_valid;
    logic       m_ready;
    logic [4:0] m_symbol;
    logic [6:0] m_repeat_extra;
    logic [2:0] m_extra_bit_count;
    logic       m_final_symbol;

    // Predictor state: length being repeated and its run count
    logic [3:0] prev_len;
    logic [7:0] run_len;

    sym_rec_t  expected_syms [$];
    stim_row_t directed_tbl [NUM_DIRECTED];
    stim_row_t random_rows [$];

    int errors       = 0;
    int lengths_sent = 0;
    int burst_left   = 0;

    code_length_run_length_encoder DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_code_length     (s_code_length),
        .s_last_length     (s_last_length),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_symbol          (m_symbol),
        .m_repeat_extra    (m_repeat_extra),
        .m_extra_bit_count (m_extra_bit_count),
        .m_final_symbol    (m_final_symbol)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic sym_rec_t mk_sym(logic [4:0] sym, logic [6:0] extra, logic [2:0] bits,
                                        logic fin);
        sym_rec_t s;
        s.symbol = sym;
        s.extra  = extra;
        s.bits   = bits;
        s.fin    = fin;
        return s;
    endfunction

    function automatic stim_row_t tbl_row(logic [3:0] len, logic last, logic typed,
                                          logic [1:0] n, sym_rec_t e0, sym_rec_t e1,
                                          sym_rec_t e2);
        stim_row_t r;
        r.len    = len;
        r.last   = last;
        r.typed  = typed;
        r.n      = n;
        r.exp[0] = e0;
        r.exp[1] = e1;
        r.exp[2] = e2;
        return r;
    endfunction

    // Emit what the pending run stands for and clear the count
    task automatic close_run(inout int n, inout sym_rec_t [2:0] r);
        logic [7:0] short_x;
        logic [7:0] long_x;
        short_x = run_len - clrle_pkg::RUN_MIN;
        long_x  = run_len - clrle_pkg::ZERO_LONG_MIN;
        if (run_len >= clrle_pkg::RUN_MIN) begin
            if (prev_len != 4'd0) begin
                r[n] = mk_sym(clrle_pkg::SYM_REPEAT, short_x[6:0], clrle_pkg::BITS_REPEAT,
                              1'b0);
            end else if (run_len <= clrle_pkg::ZERO_SHORT_MAX) begin
                r[n] = mk_sym(clrle_pkg::SYM_ZERO_SHORT, short_x[6:0],
                              clrle_pkg::BITS_ZERO_SHORT, 1'b0);
            end else begin
                r[n] = mk_sym(clrle_pkg::SYM_ZERO_LONG, long_x[6:0],
                              clrle_pkg::BITS_ZERO_LONG, 1'b0);
            end
            n++;
        end else begin
            // one or two copies go out as plain lengths
            for (int i = 0; i < run_len; i++) begin
                r[n] = mk_sym({1'b0, prev_len}, 7'd0, 3'd0, 1'b0);
                n++;
            end
        end
        run_len = 8'd0;
    endtask

    // Symbols caused by one accepted code length
    task automatic predict_symbols(input logic [3:0] len, input logic last,
                                   output int n, output sym_rec_t [2:0] r);
        n = 0;
        r = '0;
        if (len == prev_len) begin
            run_len = run_len + 8'd1;
            if (prev_len != 4'd0 && run_len >= clrle_pkg::REPEAT_MAX) begin
                r[n] = mk_sym(clrle_pkg::SYM_REPEAT,
                              7'(clrle_pkg::REPEAT_MAX - clrle_pkg::RUN_MIN),
                              clrle_pkg::BITS_REPEAT, 1'b0);
                n++;
                run_len = 8'd0;
            end else if (prev_len == 4'd0 && run_len >= clrle_pkg::ZERO_LONG_MAX) begin
                r[n] = mk_sym(clrle_pkg::SYM_ZERO_LONG,
                              7'(clrle_pkg::ZERO_LONG_MAX - clrle_pkg::ZERO_LONG_MIN),
                              clrle_pkg::BITS_ZERO_LONG, 1'b0);
                n++;
                run_len = 8'd0;
            end
        end else begin
            close_run(n, r);
            if (len != 4'd0) begin
                r[n] = mk_sym({1'b0, len}, 7'd0, 3'd0, 1'b0);
                n++;
                run_len = 8'd0;
            end else begin
                run_len = 8'd1;
            end
            prev_len = len;
        end
        // end of sequence: flush, mark the final symbol, start over
        if (last) begin
            close_run(n, r);
            if (n > 0) r[n-1].fin = 1'b1;
            prev_len = 4'd0;
            run_len  = 8'd0;
        end
    endtask

    // Offer one code length, in bursts with random gaps; called at a falling edge
    task automatic send_length(input stim_row_t row);
        int       gap;
        int       n;
        sym_rec_t [2:0] r;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_code_length <= row.len;
        s_last_length <= row.last;
        do @(posedge aclk); while (!s_ready);
        lengths_sent++;
        predict_symbols(row.len, row.last, n, r);
        if (row.typed) begin
            n = int'(row.n);
            r = row.exp;
        end
        for (int i = 0; i < n; i++) expected_syms = {expected_syms, r[i]};
        @(negedge aclk);
    endtask

    // Random sequences: mostly runs ending in a last flag, some noise
    task automatic build_random();
        int made;
        int runs;
        int run_n;
        int v;
        // zero run long enough to hit the 138 limit and keep going
        for (int k = 0; k < 141; k++)
            random_rows = {random_rows,
                           tbl_row(4'd0, 1'b0, 1'b0, 2'd0, NO_SYM, NO_SYM, NO_SYM)};
        random_rows = {random_rows, tbl_row(4'($urandom_range(1, 15)), 1'b1, 1'b0, 2'd0,
                                            NO_SYM, NO_SYM, NO_SYM)};
        made = 0;
        while (made < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
                runs = $urandom_range(1, 8);
                for (int k = 0; k < runs; k++) begin
                    v = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 15);
                    if (v == 0)
                        run_n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24)
                                                            : $urandom_range(1, 8);
                    else
                        run_n = $urandom_range(1, 14);
                    for (int j = 0; j < run_n && made < RANDOM_ITEMS; j++) begin
                        random_rows = {random_rows,
                                       tbl_row(4'(v), (k == runs-1 && j == run_n-1),
                                               1'b0, 2'd0, NO_SYM, NO_SYM, NO_SYM)};
                        made++;
                    end
                end
            end else begin
                run_n = $urandom_range(1, 10);
                for (int j = 0; j < run_n && made < RANDOM_ITEMS; j++) begin
                    random_rows = {random_rows,
                                   tbl_row(4'($urandom_range(0, 15)),
                                           ($urandom_range(0, 7) == 0), 1'b0, 2'd0,
                                           NO_SYM, NO_SYM, NO_SYM)};
                    made++;
                end
            end
        end
    endtask

    initial begin : stimulus
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_code_length = 4'd0;
        s_last_length = 1'b0;
        prev_len      = 4'd0;
        run_len       = 8'd0;

        // single lengths that close a sequence at once
        directed_tbl[0]  = tbl_row(4'd5, 1'b1, 1'b1, 2'd1, mk_sym(5'd5, 7'd0, 3'd0, 1'b1),
                                   NO_SYM, NO_SYM);
        directed_tbl[1]  = tbl_row(4'd0, 1'b1, 1'b1, 2'd1, mk_sym(5'd0, 7'd0, 3'd0, 1'b1),
                                   NO_SYM, NO_SYM);
        directed_tbl[2]  = tbl_row(4'd15, 1'b1, 1'b1, 2'd1, mk_sym(5'd15, 7'd0, 3'd0, 1'b1),
                                   NO_SYM, NO_SYM);
        // three copies flushed by the last flag as a repeat
        directed_tbl[3]  = tbl_row(4'd7, 1'b0, 1'b1, 2'd1, mk_sym(5'd7, 7'd0, 3'd0, 1'b0),
                                   NO_SYM, NO_SYM);
        directed_tbl[4]  = tbl_row(4'd7, 1'b0, 1'b1, 2'd0, NO_SYM, NO_SYM, NO_SYM);
        directed_tbl[5]  = tbl_row(4'd7, 1'b0, 1'b1, 2'd0, NO_SYM, NO_SYM, NO_SYM);
        directed_tbl[6]  = tbl_row(4'd7, 1'b1, 1'b1, 2'd1,
                                   mk_sym(clrle_pkg::SYM_REPEAT, 7'd0,
                                          clrle_pkg::BITS_REPEAT, 1'b1), NO_SYM, NO_SYM);
        // short run of two copies, then a new length: three symbols at once
        directed_tbl[7]  = tbl_row(4'd4, 1'b0, 1'b1, 2'd1, mk_sym(5'd4, 7'd0, 3'd0, 1'b0),
                                   NO_SYM, NO_SYM);
        directed_tbl[8]  = tbl_row(4'd4, 1'b0, 1'b1, 2'd0, NO_SYM, NO_SYM, NO_SYM);
        directed_tbl[9]  = tbl_row(4'd4, 1'b0, 1'b1, 2'd0, NO_SYM, NO_SYM, NO_SYM);
        directed_tbl[10] = tbl_row(4'd2, 1'b0, 1'b1, 2'd3, mk_sym(5'd4, 7'd0, 3'd0, 1'b0),
                                   mk_sym(5'd4, 7'd0, 3'd0, 1'b0),
                                   mk_sym(5'd2, 7'd0, 3'd0, 1'b0));
        directed_tbl[11] = tbl_row(4'd2, 1'b1, 1'b1, 2'd1, mk_sym(5'd2, 7'd0, 3'd0, 1'b1),
                                   NO_SYM, NO_SYM);
        // leading zeros form a short zero run
        directed_tbl[12] = tbl_row(4'd0, 1'b0, 1'b1, 2'd0, NO_SYM, NO_SYM, NO_SYM);
        directed_tbl[13] = tbl_row(4'd0, 1'b0, 1'b1, 2'd0, NO_SYM, NO_SYM, NO_SYM);
        directed_tbl[14] = tbl_row(4'd0, 1'b0, 1'b1, 2'd0, NO_SYM, NO_SYM, NO_SYM);
        directed_tbl[15] = tbl_row(4'd0, 1'b0, 1'b1, 2'd0, NO_SYM, NO_SYM, NO_SYM);
        directed_tbl[16] = tbl_row(4'd0, 1'b1, 1'b1, 2'd1,
                                   mk_sym(clrle_pkg::SYM_ZERO_SHORT, 7'd2,
                                          clrle_pkg::BITS_ZERO_SHORT, 1'b1),
                                   NO_SYM, NO_SYM);
        // six copies: full repeat goes out at once
        directed_tbl[17] = tbl_row(4'd3, 1'b0, 1'b1, 2'd1, mk_sym(5'd3, 7'd0, 3'd0, 1'b0),
                                   NO_SYM, NO_SYM);
        directed_tbl[18] = tbl_row(4'd3, 1'b0, 1'b1, 2'd0, NO_SYM, NO_SYM, NO_SYM);
        directed_tbl[19] = tbl_row(4'd3, 1'b0, 1'b1, 2'd0, NO_SYM, NO_SYM, NO_SYM);
        directed_tbl[20] = tbl_row(4'd3, 1'b0, 1'b1, 2'd0, NO_SYM, NO_SYM, NO_SYM);
        directed_tbl[21] = tbl_row(4'd3, 1'b0, 1'b1, 2'd0, NO_SYM, NO_SYM, NO_SYM);
        directed_tbl[22] = tbl_row(4'd3, 1'b0, 1'b1, 2'd0, NO_SYM, NO_SYM, NO_SYM);
        directed_tbl[23] = tbl_row(4'd3, 1'b1, 1'b1, 2'd1,
                                   mk_sym(clrle_pkg::SYM_REPEAT, 7'd3,
                                          clrle_pkg::BITS_REPEAT, 1'b1), NO_SYM, NO_SYM);
        // left open, checked by the predictor
        directed_tbl[24] = tbl_row(4'd12, 1'b0, 1'b0, 2'd0, NO_SYM, NO_SYM, NO_SYM);

        build_random();

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int k = 0; k < NUM_DIRECTED; k++) send_length(directed_tbl[k]);
        foreach (random_rows[k]) send_length(random_rows[k]);
        s_valid <= 1'b0;

        // drain, then give the block time to show any extra symbol
        while (expected_syms.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Receiver: one long hold-off once the block is busy, otherwise mixed stall patterns
    initial begin : sink
        sink_mode_t mode;
        int         span;
        bit         held;
        m_ready = 1'b0;
        held    = 1'b0;
        @(negedge aclk);
        forever begin
            if (!held && lengths_sent >= HOLD_AT) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            mode = sink_mode_t'($urandom_range(0, 2));
            span = $urandom_range(4, 40);
            repeat (span) begin
                // cut the pattern short as soon as the hold-off is due
                if (held || lengths_sent < HOLD_AT) begin
                    case (mode)
                        SINK_OPEN: begin
                            m_ready <= 1'b1;
                        end
                        SINK_COIN: begin
                            m_ready <= 1'($urandom_range(0, 1));
                        end
                        default: begin
                            m_ready <= ($urandom_range(0, 3) == 0);
                        end
                    endcase
                    @(negedge aclk);
                end
            end
        end
    end

    // Compare each output transfer with the oldest expected symbol
    always @(posedge aclk) begin : check_out
        sym_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_syms.size() == 0) begin
                $display("%0t ERROR: unexpected symbol, expected none, actual %0d",
                         $time, m_symbol);
                errors++;
            end else begin
                want = expected_syms.pop_front();
                if (m_symbol !== want.symbol) begin
                    $display("%0t ERROR: symbol expected %0d, actual %0d",
                             $time, want.symbol, m_symbol);
                    errors++;
                end
                if (m_repeat_extra !== want.extra) begin
                    $display("%0t ERROR: repeat_extra expected %0d, actual %0d",
                             $time, want.extra, m_repeat_extra);
                    errors++;
                end
                if (m_extra_bit_count !== want.bits) begin
                    $display("%0t ERROR: extra_bit_count expected %0d, actual %0d",
                             $time, want.bits, m_extra_bit_count);
                    errors++;
                end
                if (m_final_symbol !== want.fin) begin
                    $display("%0t ERROR: final_symbol expected %0d, actual %0d",
                             $time, want.fin, m_final_symbol);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
